// ----- rtl/bouncing_sprite_mover_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Bouncing sprite mover: assertion macros
// Shared assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef BOUNCING_SPRITE_MOVER_UNIT_DEFINES_SVH
`define BOUNCING_SPRITE_MOVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is held
`define BSM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, active during reset too
`define BSM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSM_ASSERT(name, clk, rst_n, prop, msg)
`define BSM_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- rtl/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Bouncing sprite mover: package
// Command codes, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // item command codes
  localparam logic CMD_TICK      = 1'b0;
  localparam logic CMD_SET_SPEED = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_POINTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_SPEED  = 3'd6;

  localparam int unsigned CFG_DATA_W = 64;

  // register reset values
  localparam logic [2:0] RST_SPRITE_WIDTH  = 3'd4;
  localparam logic [2:0] RST_SPRITE_HEIGHT = 3'd4;
  localparam logic [7:0] RST_SCREEN_WIDTH  = 8'd128;
  localparam logic [7:0] RST_SCREEN_HEIGHT = 8'd64;
  localparam logic [2:0] RST_BOUNCE_SPEED  = 3'd3;
  localparam logic signed [8:0] RST_POSITION = 9'sd1;

  // saturation bounds of a coordinate, in the widened sum
  localparam logic signed [9:0] COORD_MAX = 10'sd255;
  localparam logic signed [9:0] COORD_MIN = -10'sd256;

  // controller to datapath commands
  typedef struct packed {
    logic load_dir;   // store speed fields as direction
    logic clr_idx;    // restart point walk
    logic step_idx;   // advance to the next point
    logic move;       // update position and apply bounce
    logic emit;       // load a pixel write into the output register
    logic pixel_on;   // set (1) or clear (0) write
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic used_zero;  // no sprite points in use
    logic idx_last;   // current point is the final one
    logic out_free;   // output register can take a write this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/bsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bouncing sprite mover: controller
// Sequences items: a set-speed loads the direction; a tick runs clear pass,
// position update, draw pass; both passes are skipped with no points in use.
`default_nettype none

module bsm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               command_i,
  input  wire bsm_pkg::dp_status_t status_i,
  output bsm_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_MOVE  = 4'b0100,
    ST_DRAW  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (command_i == bsm_pkg::CMD_SET_SPEED) begin
            cmd_o.load_dir = 1'b1;
          end else begin
            cmd_o.clr_idx = 1'b1;
            state_d       = status_i.used_zero ? ST_MOVE : ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.idx_last) begin
            cmd_o.clr_idx = 1'b1;
            state_d       = ST_MOVE;
          end else begin
            cmd_o.step_idx = 1'b1;
          end
        end
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = status_i.used_zero ? ST_IDLE : ST_DRAW;
      end
      ST_DRAW: begin
        cmd_o.pixel_on = 1'b1;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step_idx = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bsm_dp.sv -----
// ----------------------------------------------------------------------------
// Bouncing sprite mover: datapath
// Configuration registers, position and direction, point walk, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_dp #(
  parameter int unsigned MAX_SPRITE_POINTS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bsm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic signed [3:0]               speed_x_i,
  input  wire logic signed [3:0]               speed_y_i,
  input  wire bsm_pkg::ctrl_cmd_t              cmd_i,
  output bsm_pkg::dp_status_t                  status_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [8:0]                    pixel_x_o,
  output logic signed [8:0]                    pixel_y_o,
  output logic                                 pixel_on_o,
  output logic                                 last_o
);

  localparam int unsigned IDX_W = (MAX_SPRITE_POINTS > 1) ? $clog2(MAX_SPRITE_POINTS) : 1;
  localparam logic [4:0]  PTS_MAX = 5'(MAX_SPRITE_POINTS);

  // configuration registers
  logic [4:0]  point_count_q;
  logic [63:0] sprite_points_q;
  logic [2:0]  sprite_width_q, sprite_height_q, bounce_speed_q;
  logic [7:0]  screen_width_q, screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q   <= '0;
      sprite_points_q <= '0;
      sprite_width_q  <= bsm_pkg::RST_SPRITE_WIDTH;
      sprite_height_q <= bsm_pkg::RST_SPRITE_HEIGHT;
      screen_width_q  <= bsm_pkg::RST_SCREEN_WIDTH;
      screen_height_q <= bsm_pkg::RST_SCREEN_HEIGHT;
      bounce_speed_q  <= bsm_pkg::RST_BOUNCE_SPEED;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsm_pkg::REG_POINT_COUNT:   point_count_q   <= cfg_wdata_i[4:0];
        bsm_pkg::REG_SPRITE_POINTS: sprite_points_q <= cfg_wdata_i[63:0];
        bsm_pkg::REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_wdata_i[2:0];
        bsm_pkg::REG_SPRITE_HEIGHT: sprite_height_q <= cfg_wdata_i[2:0];
        bsm_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[7:0];
        bsm_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[7:0];
        bsm_pkg::REG_BOUNCE_SPEED:  bounce_speed_q  <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // points in use, capped at the list size
  logic [4:0] used_pts;
  logic [4:0] idx_ext;
  logic [IDX_W-1:0] idx_q, idx_d;

  assign used_pts = (point_count_q > PTS_MAX) ? PTS_MAX : point_count_q;
  assign idx_ext  = 5'(idx_q);

  // point walk counter
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
    end else if (cmd_i.step_idx) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // position and direction state
  logic signed [8:0] pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic signed [3:0] dir_x_q, dir_y_q, dir_x_d, dir_y_d;
  logic signed [9:0] sum_x, sum_y;
  logic signed [3:0] bs_pos, bs_neg;

  assign sum_x  = {pos_x_q[8], pos_x_q} + {{6{dir_x_q[3]}}, dir_x_q};
  assign sum_y  = {pos_y_q[8], pos_y_q} + {{6{dir_y_q[3]}}, dir_y_q};
  assign bs_pos = $signed({1'b0, bounce_speed_q});
  assign bs_neg = -bs_pos;

  // saturated move, then the bounce chain on the new position
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    dir_x_d = dir_x_q;
    dir_y_d = dir_y_q;
    if (cmd_i.load_dir) begin
      dir_x_d = speed_x_i;
      dir_y_d = speed_y_i;
    end else if (cmd_i.move) begin
      if (sum_x > bsm_pkg::COORD_MAX) begin
        pos_x_d = 9'sd255;
      end else if (sum_x < bsm_pkg::COORD_MIN) begin
        pos_x_d = -9'sd256;
      end else begin
        pos_x_d = sum_x[8:0];
      end
      if (sum_y > bsm_pkg::COORD_MAX) begin
        pos_y_d = 9'sd255;
      end else if (sum_y < bsm_pkg::COORD_MIN) begin
        pos_y_d = -9'sd256;
      end else begin
        pos_y_d = sum_y[8:0];
      end
      if (pos_x_d < 9'sd1) begin
        dir_x_d = bs_pos;
      end else if (({pos_x_d[8], pos_x_d} + $signed({7'b0, sprite_width_q}))
                   > $signed({2'b0, screen_width_q})) begin
        dir_x_d = bs_neg;
      end else if (pos_y_d < 9'sd1) begin
        dir_y_d = bs_pos;
      end else if (({pos_y_d[8], pos_y_d} + $signed({7'b0, sprite_height_q}))
                   > $signed({2'b0, screen_height_q})) begin
        dir_y_d = bs_neg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= bsm_pkg::RST_POSITION;
      pos_y_q <= bsm_pkg::RST_POSITION;
      dir_x_q <= '0;
      dir_y_q <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      dir_x_q <= dir_x_d;
      dir_y_q <= dir_y_d;
    end
  end

  // pixel of the current point, saturated at the top
  logic [3:0]        entry;
  logic signed [9:0] pix_x_sum, pix_y_sum;
  logic signed [8:0] pix_x, pix_y;

  assign entry     = sprite_points_q[idx_q*4 +: 4];
  assign pix_x_sum = {pos_x_q[8], pos_x_q} + $signed({8'b0, entry[1:0]});
  assign pix_y_sum = {pos_y_q[8], pos_y_q} + $signed({8'b0, entry[3:2]});
  assign pix_x     = (pix_x_sum > bsm_pkg::COORD_MAX) ? 9'sd255 : pix_x_sum[8:0];
  assign pix_y     = (pix_y_sum > bsm_pkg::COORD_MAX) ? 9'sd255 : pix_y_sum[8:0];

  // status back to the controller
  assign status_o.used_zero = (used_pts == 5'd0);
  assign status_o.idx_last  = (idx_ext == (used_pts - 5'd1));
  assign status_o.out_free  = !out_valid_o || !out_stall_i;

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pixel_x_o  <= pix_x;
      pixel_y_o  <= pix_y;
      pixel_on_o <= cmd_i.pixel_on;
      last_o     <= cmd_i.pixel_on && status_o.idx_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/bouncing_sprite_mover_unit.sv -----
// ----------------------------------------------------------------------------
// Bouncing sprite mover unit
// Moves a point-list sprite across a screen and emits its pixel writes.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid_i/in_stall_o   command_i, speed_x_i, speed_y_i
//  out      out_valid_o/out_stall_i pixel_x_o, pixel_y_o, pixel_on_o, last_o
//  cfg      cfg_we_i                cfg_index_i, cfg_wdata_i
//
//  a set-speed item loads the direction and gives no pixel writes
//  a tick runs the clear pass, the move/bounce step and the draw pass, one write
//  per cycle through each pass unless the output stalls; with no points, no passes
//  a stall on the output holds the pass at its current point
//  reset is asynchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

`include "bouncing_sprite_mover_unit_defines.svh"

module bouncing_sprite_mover_unit #(
  parameter int unsigned MAX_SPRITE_POINTS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           command_i,
  input  wire logic signed [3:0]              speed_x_i,
  input  wire logic signed [3:0]              speed_y_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [8:0]                   pixel_x_o,
  output logic signed [8:0]                   pixel_y_o,
  output logic                                pixel_on_o,
  output logic                                last_o
);

  bsm_pkg::ctrl_cmd_t cmd;
  bsm_pkg::dp_status_t status;

  // tick sequencer
  bsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // registers, arithmetic and output stage
  bsm_dp #(
    .MAX_SPRITE_POINTS (MAX_SPRITE_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .speed_x_i   (speed_x_i),
    .speed_y_i   (speed_y_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .pixel_on_o  (pixel_on_o),
    .last_o      (last_o)
  );

  // checks
  `BSM_ASSERT(a_last_only_on_set, clk_i, rst_ni, (out_valid_o && last_o) |-> pixel_on_o, "last marked on a clear write")
  `BSM_ASSERT(a_tick_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o && (command_i == bsm_pkg::CMD_TICK)) |=> in_stall_o, "tick accepted without going busy")
  `BSM_ASSERT(a_clear_while_busy, clk_i, rst_ni, (out_valid_o && !pixel_on_o) |-> in_stall_o, "clear write pending while idle")

endmodule

`default_nettype wire

// ----- sim/bsm_pixel_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bouncing sprite mover: pixel write checker
// Watches the register port and both item channels. It keeps its own copy of
// the sprite registers, position and direction, predicts the clear and draw
// passes of every accepted tick, and compares each accepted pixel write with
// the oldest prediction.
// ----------------------------------------------------------------------------
module bsm_pixel_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           command_i,
  input  logic signed [3:0]              speed_x_i,
  input  logic signed [3:0]              speed_y_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic signed [8:0]              pixel_x_i,
  input  logic signed [8:0]              pixel_y_i,
  input  logic                           pixel_on_i,
  input  logic                           last_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import bsm_pkg::*;

  localparam int POINT_SLOTS = 16;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic              on;
    logic              last;
  } pixel_write_t;

  // shadow copy of the registers
  logic [4:0]  point_count;
  logic [63:0] sprite_points;
  logic [2:0]  sprite_w;
  logic [2:0]  sprite_h;
  logic [7:0]  screen_w;
  logic [7:0]  screen_h;
  logic [2:0]  bounce_speed;

  // sprite state
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic signed [3:0] dir_x;
  logic signed [3:0] dir_y;

  pixel_write_t expected_writes[$];

  // saturate a widened coordinate to the 9-bit signed range
  function automatic logic signed [8:0] clamp_coord(input int v);
    if (v < -256) return 9'h100;
    if (v > 255) return 9'h0FF;
    return v[8:0];
  endfunction

  // one pass over the point list at the current position
  function automatic void queue_pass(input logic on);
    int n;
    logic [3:0] entry;
    pixel_write_t w;
    n = (int'(point_count) > POINT_SLOTS) ? POINT_SLOTS : int'(point_count);
    for (int i = 0; i < n; i++) begin
      entry = sprite_points[i*4 +: 4];
      w.x = clamp_coord(int'(pos_x) + int'(entry[1:0]));
      w.y = clamp_coord(int'(pos_y) + int'(entry[3:2]));
      w.on = on;
      w.last = on && (i == n - 1);
      expected_writes.push_back(w);
    end
  endfunction

  // set speed stores the direction; a tick clears, moves, bounces and draws
  function automatic void predict_item(input logic cmd, input logic signed [3:0] sx,
                                       input logic signed [3:0] sy);
    logic signed [3:0] up_speed;
    up_speed = $signed({1'b0, bounce_speed});
    if (cmd == CMD_SET_SPEED) begin
      dir_x = sx;
      dir_y = sy;
    end else begin
      queue_pass(1'b0);
      pos_x = clamp_coord(int'(pos_x) + int'(dir_x));
      pos_y = clamp_coord(int'(pos_y) + int'(dir_y));
      // first matching edge wins
      if (int'(pos_x) < 1) begin
        dir_x = up_speed;
      end else if (int'(pos_x) + int'(sprite_w) > int'(screen_w)) begin
        dir_x = -up_speed;
      end else if (int'(pos_y) < 1) begin
        dir_y = up_speed;
      end else if (int'(pos_y) + int'(sprite_h) > int'(screen_h)) begin
        dir_y = -up_speed;
      end
      queue_pass(1'b1);
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_POINT_COUNT:   point_count = value[4:0];
      REG_SPRITE_POINTS: sprite_points = value[63:0];
      REG_SPRITE_WIDTH:  sprite_w = value[2:0];
      REG_SPRITE_HEIGHT: sprite_h = value[2:0];
      REG_SCREEN_WIDTH:  screen_w = value[7:0];
      REG_SCREEN_HEIGHT: screen_h = value[7:0];
      REG_BOUNCE_SPEED:  bounce_speed = value[2:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // sample both channels and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_write_t want;
    if (!rst_ni) begin
      point_count   = '0;
      sprite_points = '0;
      sprite_w      = RST_SPRITE_WIDTH;
      sprite_h      = RST_SPRITE_HEIGHT;
      screen_w      = RST_SCREEN_WIDTH;
      screen_h      = RST_SCREEN_HEIGHT;
      bounce_speed  = RST_BOUNCE_SPEED;
      pos_x         = RST_POSITION;
      pos_y         = RST_POSITION;
      dir_x         = '0;
      dir_y         = '0;
      expected_writes.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      pending_o    <= 0;
    end else begin
      // results first: none can stem from an item taken at this same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("pixel write x %0d y %0d on %0b last %0b, none expected",
                                    pixel_x_i, pixel_y_i, pixel_on_i, last_i));
        end else begin
          want = expected_writes.pop_front();
          checked_o++;
          if (pixel_x_i !== want.x || pixel_y_i !== want.y ||
              pixel_on_i !== want.on || last_i !== want.last) begin
            report_mismatch($sformatf(
              "write %0d: got x %0d y %0d on %0b last %0b, want x %0d y %0d on %0b last %0b",
              checked_o, pixel_x_i, pixel_y_i, pixel_on_i, last_i,
              want.x, want.y, want.on, want.last));
          end
        end
      end
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) predict_item(command_i, speed_x_i, speed_y_i);
      pending_o <= expected_writes.size();
    end
  end

endmodule

// ----- sim/bouncing_sprite_mover_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bouncing sprite mover unit: regression bench
// Drives register settings and tick/set-speed items into the mover, with
// bursty input and a stalling pixel channel, and lets the checker predict and
// compare every pixel write. A directed opening covers empty and full
// sprites, oversize point counts and odd sizes; saturation runs and random
// phases follow.
// ----------------------------------------------------------------------------
module bouncing_sprite_mover_unit_tb;
  import bsm_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 16;
  localparam int SAT_TICKS     = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [3:0] SPD_MAX  = 4'sd7;
  localparam logic signed [3:0] SPD_MIN  = 4'sh8;
  localparam logic signed [3:0] SPD_ZERO = 4'sd0;

  typedef struct {
    logic [4:0]  point_count;
    logic [63:0] sprite_points;
    logic [2:0]  sprite_w;
    logic [2:0]  sprite_h;
    logic [7:0]  screen_w;
    logic [7:0]  screen_h;
    logic [2:0]  bounce_speed;
  } sprite_setup_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  command   = CMD_TICK;
  logic signed [3:0]     speed_x   = '0;
  logic signed [3:0]     speed_y   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [8:0]     pixel_x;
  logic signed [8:0]     pixel_y;
  logic                  pixel_on;
  logic                  last;

  int fail_count;
  int pending;
  int checked;

  int burst_left    = 0;
  int stall_run     = 0;
  int items_sent    = 0;
  int ticks_sent    = 0;
  int setups_loaded = 0;

  bouncing_sprite_mover_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .command_i   (command),
    .speed_x_i   (speed_x),
    .speed_y_i   (speed_y),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .pixel_on_o  (pixel_on),
    .last_o      (last)
  );

  bsm_pixel_checker pixel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .command_i    (command),
    .speed_x_i    (speed_x),
    .speed_y_i    (speed_y),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .pixel_on_i   (pixel_on),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #1 clk_i = ~clk_i;

  // pixel channel back-pressure: short stall runs, short or long open runs
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 6);
    end
  end

  function automatic sprite_setup_t make_setup(input logic [4:0] pc, input logic [63:0] pts,
                                               input logic [2:0] sw, input logic [2:0] sh,
                                               input logic [7:0] scw, input logic [7:0] sch,
                                               input logic [2:0] bs);
    sprite_setup_t s;
    s.point_count   = pc;
    s.sprite_points = pts;
    s.sprite_w      = sw;
    s.sprite_h      = sh;
    s.screen_w      = scw;
    s.screen_h      = sch;
    s.bounce_speed  = bs;
    return s;
  endfunction

  // mostly small sprites, sometimes full or oversize, sizes over the whole field
  function automatic sprite_setup_t random_setup();
    sprite_setup_t s;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) s.point_count = 5'($urandom_range(0, 4));
    else if (pick < 9) s.point_count = 5'($urandom_range(5, 16));
    else s.point_count = 5'($urandom_range(17, 31));
    s.sprite_points = {$urandom(), $urandom()};
    s.sprite_w      = 3'($urandom_range(0, 7));
    s.sprite_h      = 3'($urandom_range(0, 7));
    s.screen_w      = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(8, 255));
    s.screen_h      = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(8, 255));
    s.bounce_speed  = 3'($urandom_range(0, 7));
    return s;
  endfunction

  // leaves the write enable high; the caller lowers it after the batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  // every register, optionally with junk above the register width
  task automatic load_setup(input sprite_setup_t s, input bit junk);
    logic [63:0] fill;
    fill = junk ? {$urandom(), $urandom()} : '0;
    write_reg(REG_POINT_COUNT,   {fill[63:5], s.point_count});
    write_reg(REG_SPRITE_POINTS, s.sprite_points);
    write_reg(REG_SPRITE_WIDTH,  {fill[63:3], s.sprite_w});
    write_reg(REG_SPRITE_HEIGHT, {fill[63:3], s.sprite_h});
    write_reg(REG_SCREEN_WIDTH,  {fill[63:8], s.screen_w});
    write_reg(REG_SCREEN_HEIGHT, {fill[63:8], s.screen_h});
    write_reg(REG_BOUNCE_SPEED,  {fill[63:3], s.bounce_speed});
    if (junk) write_reg(REG_SPARE, fill);
    cfg_we <= 1'b0;
    setups_loaded++;
  endtask

  // one item, with a random gap whenever a burst runs out
  task automatic send_item(input logic cmd, input logic signed [3:0] sx,
                           input logic signed [3:0] sy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    command  <= cmd;
    speed_x  <= sx;
    speed_y  <= sy;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  // hold the input until every predicted write is out, then idle a while
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  initial begin
    int run;
    int phase_end;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    // empty sprite under reset settings: ticks move and bounce silently
    send_item(CMD_TICK, SPD_MIN, SPD_MAX);
    send_item(CMD_SET_SPEED, SPD_MIN, SPD_MIN);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_TICK, SPD_MAX, SPD_MIN);
    settle(SETTLE_CYCLES);

    // full sprite with every offset pattern once
    load_setup(make_setup(5'd16, 64'hFEDC_BA98_7654_3210, 3'd4, 3'd4, 8'd128, 8'd64, 3'd7),
               1'b0);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_SET_SPEED, SPD_MAX, SPD_MAX);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_TICK, SPD_MIN, SPD_MIN);
    send_item(CMD_SET_SPEED, SPD_MIN, SPD_MIN);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_TICK, SPD_MAX, SPD_MIN);
    settle(SETTLE_CYCLES);

    // oversize point count, largest offsets, largest sizes, no bounce speed
    load_setup(make_setup(5'd31, '1, 3'd7, 3'd7, 8'd255, 8'd255, 3'd0), 1'b1);
    send_item(CMD_SET_SPEED, SPD_MAX, SPD_MIN);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_SET_SPEED, SPD_ZERO, SPD_ZERO);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    settle(SETTLE_CYCLES);

    // zero sprite and screen sizes, single point
    load_setup(make_setup(5'd1, {$urandom(), $urandom()}, 3'd0, 3'd0, 8'd0, 8'd0, 3'd5), 1'b1);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_SET_SPEED, -4'sd1, 4'sd1);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    send_item(CMD_TICK, SPD_ZERO, SPD_ZERO);
    settle(SETTLE_CYCLES);

    // x edge always hit with no speed: x frozen, y runs down into saturation
    load_setup(make_setup(5'd2, {$urandom(), $urandom()}, 3'd1, 3'd4, 8'd0, 8'd64, 3'd0),
               1'b0);
    send_item(CMD_SET_SPEED, SPD_ZERO, SPD_MIN);
    repeat (SAT_TICKS) send_item(CMD_TICK, 4'($urandom()), 4'($urandom()));
    settle(SETTLE_CYCLES);

    // no right edge: x climbs into saturation and the pixel clamp
    load_setup(make_setup(5'd2, {$urandom(), $urandom()}, 3'd0, 3'd1, 8'd255, 8'd255, 3'd0),
               1'b0);
    send_item(CMD_SET_SPEED, SPD_MAX, SPD_ZERO);
    repeat (SAT_TICKS) send_item(CMD_TICK, 4'($urandom()), 4'($urandom()));
    settle(SETTLE_CYCLES);

    // random phases: mostly set speed then a few ticks, some loose items
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_setup(random_setup(), 1'($urandom_range(0, 1)));
      phase_end = items_sent + PHASE_ITEMS;
      run = 0;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) != 0) begin
          send_item(CMD_SET_SPEED, 4'($urandom()), 4'($urandom()));
          repeat ($urandom_range(1, 5)) send_item(CMD_TICK, 4'($urandom()), 4'($urandom()));
        end else begin
          repeat ($urandom_range(1, 3))
            send_item(1'($urandom_range(0, 1)), 4'($urandom()), 4'($urandom()));
        end
        run++;
        // let the pixel channel run dry now and then
        if (run == 2 || $urandom_range(0, 7) == 0) settle(0);
      end
      settle(SETTLE_CYCLES);
    end

    $display("summary: %0d items (%0d ticks), %0d pixel writes checked, %0d register settings",
             items_sent, ticks_sent, checked, setups_loaded);
    $display("summary: empty, full and oversize sprites, odd sizes, saturation on both axes");
    if (fail_count == 0) begin
      $display("bouncing_sprite_mover_unit regression: pass");
    end else begin
      $display("bouncing_sprite_mover_unit regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("timeout with %0d pixel writes outstanding", pending);
    $display("bouncing_sprite_mover_unit regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bsm_pkg.sv
rtl/bsm_ctrl.sv
rtl/bsm_dp.sv
rtl/bouncing_sprite_mover_unit.sv
sim/bsm_pixel_checker.sv
sim/bouncing_sprite_mover_unit_tb.sv
